/* design/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg
// Types and fixed constants of the polyphonic voice allocator: item layouts,
// mode and register codes, the voice record and the shared unit interface.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Mode codes of an input item.
  localparam logic [2:0] MODE_NOTE_ON  = 3'd0;
  localparam logic [2:0] MODE_NOTE_OFF = 3'd1;
  localparam logic [2:0] MODE_ALL_OFF  = 3'd2;
  localparam logic [2:0] MODE_RESET    = 3'd3;
  localparam logic [2:0] MODE_TICK     = 3'd4;

  // Configuration register indexes.
  localparam int          CFG_IDX_W       = 2;
  localparam logic [1:0]  CFG_STEAL       = 2'd0;
  localparam logic [1:0]  CFG_ENVELOPES   = 2'd1;
  localparam logic [1:0]  CFG_FADE_STEP   = 2'd2;

  // Q1.16 fade values.
  localparam logic [16:0] FADE_UNITY      = 17'd65536;
  localparam logic [16:0] FADE_STEP_RESET = 17'd2913;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] envelope_busy;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  voice_slot;
    logic        accepted;
    logic        stolen;
    logic [15:0] ended_mask;
    logic [15:0] active_mask;
    logic [15:0] gate_mask;
  } out_item_t;

  typedef struct packed {
    logic        steal_enable;
    logic        envelopes_present;
    logic [16:0] fade_step;
  } cfg_t;

  // Per-voice payload held in the voice store.
  typedef struct packed {
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] age;
    logic [16:0] fade;
  } voice_rec_t;

  // Shared compare / subtract unit.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        lt;
    logic        eq;
    logic [31:0] sat_diff;
  } alu_rsp_t;

endpackage

/* design/pva_voice_mem.sv */
// ----------------------------------------------------------------------------
// pva_voice_mem
// Voice store: note, velocity, age stamp and fade of every voice, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module pva_voice_mem #(
  parameter int NUM_VOICES = 16,
  parameter int VW         = 4
) (
  input  logic                  clk,
  input  logic                  we_all,
  input  logic                  we_fade,
  input  logic [VW-1:0]         waddr,
  input  pva_pkg::voice_rec_t   wdata,
  input  logic [VW-1:0]         raddr,
  output pva_pkg::voice_rec_t   rdata
);
  import pva_pkg::*;

  logic [6:0]  note_mem [NUM_VOICES];
  logic [6:0]  vel_mem  [NUM_VOICES];
  logic [31:0] age_mem  [NUM_VOICES];
  logic [16:0] fade_mem [NUM_VOICES];

  voice_rec_t rdata_r;

  // A note on writes the whole record; a block tick writes the fade only.
  always_ff @(posedge clk) begin
    if (we_all) begin
      note_mem[waddr] <= wdata.note;
      vel_mem[waddr]  <= wdata.velocity;
      age_mem[waddr]  <= wdata.age;
    end
    if (we_all || we_fade) begin
      fade_mem[waddr] <= wdata.fade;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rdata_r.note     <= note_mem[raddr];
    rdata_r.velocity <= vel_mem[raddr];
    rdata_r.age      <= age_mem[raddr];
    rdata_r.fade     <= fade_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/pva_alu.sv */
// ----------------------------------------------------------------------------
// pva_alu
// Shared unit: one 32-bit subtract gives less-than, equality and a
// difference that stops at zero.
// ----------------------------------------------------------------------------
module pva_alu (
  input  pva_pkg::alu_req_t req,
  output pva_pkg::alu_rsp_t rsp
);
  import pva_pkg::*;

  logic [32:0] diff;

  // The borrow of the subtract is the less-than result.
  always_comb begin
    diff         = {1'b0, req.a} - {1'b0, req.b};
    rsp.lt       = diff[32];
    rsp.eq       = (req.a == req.b);
    rsp.sat_diff = (diff[32] || (req.a == req.b)) ? 32'd0 : diff[31:0];
  end

endmodule

/* design/pva_core.sv */
// ----------------------------------------------------------------------------
// pva_core
// Sequencer of the allocator: walks the voices one per cycle through the
// voice store and the shared unit, then commits the item's outcome.
// ----------------------------------------------------------------------------
module pva_core #(
  parameter int NUM_VOICES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pva_pkg::in_item_t   item,
  input  pva_pkg::cfg_t       cfg,
  output logic                busy,
  output logic                res_valid,
  input  logic                res_take,
  output pva_pkg::out_item_t  res
);
  import pva_pkg::*;

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  in_item_t              item_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  pv_r, pv_nxt;
  logic [VW-1:0]         pidx_r, pidx_nxt;
  logic [NUM_VOICES-1:0] active_r, active_nxt;
  logic [NUM_VOICES-1:0] gate_r, gate_nxt;
  logic [NUM_VOICES-1:0] ended_r, ended_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [VW-1:0]         free_idx_r, free_idx_nxt;
  logic [VW-1:0]         best_idx_r, best_idx_nxt;
  logic [31:0]           best_age_r, best_age_nxt;
  logic [31:0]           age_clock_r, age_clock_nxt;
  logic [3:0]            res_idx_r, res_idx_nxt;
  logic                  res_acc_r, res_acc_nxt;
  logic                  res_stl_r, res_stl_nxt;

  logic                  we_all, we_fade;
  logic [VW-1:0]         waddr, raddr;
  voice_rec_t            wdata, rdata;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [NUM_VOICES-1:0] busy_ext;
  logic [15:0]           act16, gate16, ended16;
  logic [16:0]           new_fade;
  logic                  fading, done;
  logic                  commit;
  logic [VW-1:0]         pick;
  logic [VW+3:0]         pick_ext;

  pva_voice_mem #(
    .NUM_VOICES (NUM_VOICES),
    .VW         (VW)
  ) u_mem (
    .clk     (clk),
    .we_all  (we_all),
    .we_fade (we_fade),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  pva_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Map between voices and the 16-bit item masks; voices from 16 upwards
  // see no busy bit and show in no mask.
  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_busy
    if (i < 16) begin : g_lo
      assign busy_ext[i] = item_r.envelope_busy[i];
    end else begin : g_hi
      assign busy_ext[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_mask
    if (i < NUM_VOICES) begin : g_in
      assign act16[i]   = active_r[i];
      assign gate16[i]  = gate_r[i];
      assign ended16[i] = ended_r[i];
    end else begin : g_out
      assign act16[i]   = 1'b0;
      assign gate16[i]  = 1'b0;
      assign ended16[i] = 1'b0;
    end
  end

  // Operand selection for the shared unit by mode.
  always_comb begin
    alu_req = '0;
    case (item_r.mode)
      MODE_NOTE_ON: begin
        alu_req.a = rdata.age;
        alu_req.b = best_age_r;
      end
      MODE_NOTE_OFF: begin
        alu_req.a = {25'd0, rdata.note};
        alu_req.b = {25'd0, item_r.note};
      end
      MODE_TICK: begin
        alu_req.a = {15'd0, rdata.fade};
        alu_req.b = {15'd0, cfg.fade_step};
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Fade and finish test of the voice under way in a block tick.
  always_comb begin
    fading   = !cfg.envelopes_present && !gate_r[pidx_r];
    new_fade = fading ? alu_rsp.sat_diff[16:0] : rdata.fade;
    done     = cfg.envelopes_present ? !busy_ext[pidx_r] : (new_fade == 17'd0);
  end

  // Choice of voice for a note on.
  always_comb begin
    commit   = free_found_r || cfg.steal_enable;
    pick     = free_found_r ? free_idx_r : best_idx_r;
    pick_ext = (VW + 4)'(pick);
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    active_nxt     = active_r;
    gate_nxt       = gate_r;
    ended_nxt      = ended_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_idx_nxt   = best_idx_r;
    best_age_nxt   = best_age_r;
    age_clock_nxt  = age_clock_r;
    res_idx_nxt    = res_idx_r;
    res_acc_nxt    = res_acc_r;
    res_stl_nxt    = res_stl_r;
    we_all         = 1'b0;
    we_fade        = 1'b0;
    waddr          = pidx_r;
    wdata          = '0;
    raddr          = cnt_r[VW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          ended_nxt      = '0;
          if (item.mode == MODE_NOTE_ON || item.mode == MODE_NOTE_OFF ||
              item.mode == MODE_TICK) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_WALK: begin
        // Issue the next read while the previous voice is handled.
        if (cnt_r < CW'(NUM_VOICES)) begin
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[VW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end

        if (pv_r) begin
          case (item_r.mode)
            MODE_NOTE_ON: begin
              if (!active_r[pidx_r] && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = pidx_r;
              end
              if (pidx_r == '0 || alu_rsp.lt) begin
                best_idx_nxt = pidx_r;
                best_age_nxt = rdata.age;
              end
            end
            MODE_NOTE_OFF: begin
              if (active_r[pidx_r] && alu_rsp.eq) begin
                gate_nxt[pidx_r] = 1'b0;
              end
            end
            MODE_TICK: begin
              if (active_r[pidx_r]) begin
                we_fade    = fading;
                wdata.fade = new_fade;
                if (!gate_r[pidx_r] && done) begin
                  active_nxt[pidx_r] = 1'b0;
                  ended_nxt[pidx_r]  = 1'b1;
                end
              end
            end
            default: begin
              pv_nxt = 1'b0;
            end
          endcase
        end
      end

      S_FINISH: begin
        res_idx_nxt = 4'd0;
        res_acc_nxt = 1'b0;
        res_stl_nxt = 1'b0;
        state_nxt   = S_DONE;
        case (item_r.mode)
          MODE_NOTE_ON: begin
            if (commit) begin
              age_clock_nxt    = age_clock_r + 32'd1;
              we_all           = 1'b1;
              waddr            = pick;
              wdata.note       = item_r.note;
              wdata.velocity   = item_r.velocity;
              wdata.age        = age_clock_r + 32'd1;
              wdata.fade       = FADE_UNITY;
              active_nxt[pick] = 1'b1;
              gate_nxt[pick]   = 1'b1;
              res_idx_nxt      = pick_ext[3:0];
              res_acc_nxt      = 1'b1;
              res_stl_nxt      = !free_found_r;
            end
          end
          MODE_ALL_OFF: begin
            gate_nxt = '0;
          end
          MODE_RESET: begin
            active_nxt = '0;
            gate_nxt   = '0;
          end
          default: begin
            res_acc_nxt = 1'b0;
          end
        endcase
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= 1'b0;
      active_r    <= '0;
      gate_r      <= '0;
      age_clock_r <= '0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      active_r    <= active_nxt;
      gate_r      <= gate_nxt;
      age_clock_r <= age_clock_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    if (start && state_r == S_IDLE) begin
      item_r <= item;
    end
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    ended_r      <= ended_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_age_r   <= best_age_nxt;
    res_idx_r    <= res_idx_nxt;
    res_acc_r    <= res_acc_nxt;
    res_stl_r    <= res_stl_nxt;
  end

  // Result of the finished item; masks show the state after the item.
  always_comb begin
    res.voice_slot  = res_idx_r;
    res.accepted    = res_acc_r;
    res.stolen      = res_stl_r;
    res.ended_mask  = (item_r.mode == MODE_TICK) ? ended16 : 16'd0;
    res.active_mask = act16;
    res.gate_mask   = gate16;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);

endmodule

/* design/polyphonic_voice_allocator_unit.sv */
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit
// Voice pool with oldest-voice stealing, note off, all notes off, reset and
// a per-block release fade or envelope-busy end of voices.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A note on, note off or block tick
// walks every voice once, reading one voice per cycle from the voice store
// into a single shared compare and subtract unit, then a finish step sets
// the result; all notes off, reset and the unused mode codes skip the walk
// and go straight to the finish step. in_stall is high while an item is
// under way or its result cannot yet move into the output register; a result
// that waits there does not hold up the next item. Configuration writes are
// always taken and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_unit #(
  parameter int NUM_VOICES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pva_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pva_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [16:0]                  cfg_data
);
  import pva_pkg::*;

  cfg_t      cfg_r;
  logic      core_busy;
  logic      res_valid;
  logic      res_take;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;

  pva_core #(
    .NUM_VOICES (NUM_VOICES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && !in_stall),
    .item      (in_data),
    .cfg       (cfg_r),
    .busy      (core_busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steal_enable      <= 1'b1;
      cfg_r.envelopes_present <= 1'b0;
      cfg_r.fade_step         <= FADE_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEAL:     cfg_r.steal_enable      <= cfg_data[0];
        CFG_ENVELOPES: cfg_r.envelopes_present <= cfg_data[0];
        CFG_FADE_STEP: cfg_r.fade_step         <= cfg_data;
        default:       cfg_r                   <= cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Output register: a finished item moves in when it is empty or emptying.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign in_stall  = core_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* test/polyphonic_voice_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit_tb
// Self-checking bench for the voice allocator. A scripted opening covers every
// mode, the field extremes and stealing from a full pool. Random phases then
// run under several register settings, with random gaps and output stalls.
// Every result is checked field by field against a voice pool model kept in
// the bench, or for some scripted items against results written in the script.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_unit_tb;
  import pva_pkg::*;

  localparam int NUM_VOICES = 16;

  // Mode codes that the block leaves unused, and the spare register index.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [1:0] CFG_SPARE     = 2'd3;

  // Lengths of the pauses, the watchdog limit and the long output hold.
  localparam int DRAIN_CYCLES  = 25;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 320;

  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t want;
  } script_row_t;

  typedef struct {
    bit          steal;
    bit          env;
    logic [16:0] fade;
    int          gap;
    int          stall;
    int          on_pct;
    int          items;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;

  // Model of the voice pool and its registers.
  bit          pool_active [NUM_VOICES];
  bit          pool_gate [NUM_VOICES];
  logic [6:0]  pool_note [NUM_VOICES];
  logic [6:0]  pool_velocity [NUM_VOICES];
  logic [31:0] pool_age [NUM_VOICES];
  logic [16:0] pool_fade [NUM_VOICES];
  logic [31:0] age_clock;
  bit          steal_on;
  bit          env_on;
  logic [16:0] fade_dec;

  out_item_t   due_results[$];
  script_row_t script[$];
  phase_t      phases[$];
  logic [6:0]  note_set [8];
  int          gap_max;
  int          stall_max;
  int          on_pct;
  int          mismatch_count;
  int          quiet_cycles;

  polyphonic_voice_allocator_unit #(
    .NUM_VOICES(NUM_VOICES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one item to the pool model and returns the result it gives.
  function automatic out_item_t predict_voice_step(input in_item_t it);
    out_item_t r;
    int        pick;
    bit        finished;
    r = '0;
    case (it.mode)
      MODE_NOTE_ON: begin
        pick = -1;
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (!pool_active[v] && pick < 0) pick = v;
        end
        // A full pool gives up its oldest voice, or drops the note.
        if (pick < 0 && steal_on) begin
          pick = 0;
          for (int v = 1; v < NUM_VOICES; v++) begin
            if (pool_age[v] < pool_age[pick]) pick = v;
          end
          r.stolen = 1'b1;
        end
        if (pick >= 0) begin
          age_clock           = age_clock + 32'd1;
          pool_active[pick]   = 1'b1;
          pool_gate[pick]     = 1'b1;
          pool_note[pick]     = it.note;
          pool_velocity[pick] = it.velocity;
          pool_age[pick]      = age_clock;
          pool_fade[pick]     = FADE_UNITY;
          r.voice_slot        = pick[3:0];
          r.accepted          = 1'b1;
        end
      end
      MODE_NOTE_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (pool_active[v] && pool_note[v] == it.note) pool_gate[v] = 1'b0;
        end
      end
      MODE_ALL_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++) pool_gate[v] = 1'b0;
      end
      MODE_RESET: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          pool_active[v] = 1'b0;
          pool_gate[v]   = 1'b0;
        end
      end
      MODE_TICK: begin
        // Released voices fade when no envelopes are present, then finished ones are retired.
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (pool_active[v]) begin
            if (!env_on && !pool_gate[v]) begin
              pool_fade[v] = (pool_fade[v] > fade_dec) ? pool_fade[v] - fade_dec : 17'd0;
            end
            finished = env_on ? !it.envelope_busy[v] : (pool_fade[v] == 17'd0);
            if (!pool_gate[v] && finished) begin
              pool_active[v]  = 1'b0;
              r.ended_mask[v] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    for (int v = 0; v < NUM_VOICES; v++) begin
      r.active_mask[v] = pool_active[v];
      r.gate_mask[v]   = pool_gate[v];
    end
    return r;
  endfunction

  function automatic string show_result(input out_item_t r);
    return $sformatf("voice %0d acc %0b stolen %0b ended %h active %h gate %h",
                     r.voice_slot, r.accepted, r.stolen, r.ended_mask,
                     r.active_mask, r.gate_mask);
  endfunction

  // Random item, weighted towards note traffic on a small set of notes.
  function automatic in_item_t random_event();
    in_item_t it;
    int       roll;
    it.velocity      = 7'($urandom_range(0, 127));
    it.envelope_busy = 16'($urandom);
    if ($urandom_range(0, 99) < 70) it.note = note_set[$urandom_range(0, 7)];
    else it.note = 7'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < on_pct) it.mode = MODE_NOTE_ON;
    else if (roll < on_pct + 25) it.mode = MODE_NOTE_OFF;
    else if (roll < on_pct + 28) it.mode = MODE_ALL_OFF;
    else if (roll < on_pct + 30) it.mode = MODE_RESET;
    else if (roll < on_pct + 34) it.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    else it.mode = MODE_TICK;
    return it;
  endfunction

  task automatic add_row(input logic [2:0] mode, input logic [6:0] note,
                         input logic [6:0] vel, input logic [15:0] busy,
                         input int reps, input bit typed, input out_item_t want);
    script_row_t row;
    row.item  = {mode, note, vel, busy};
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    script.insert(script.size(), row);
  endtask

  // Offers one item after a random gap and records its expected result.
  task automatic offer_event(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_voice_step(it);
    due_results.insert(due_results.size(), typed ? want : predicted);
  endtask

  // Register writes, made only once every result has come back.
  task automatic program_regs(input bit steal, input bit env, input logic [16:0] fade,
                              input bit spare);
    logic [1:0]  idx [4];
    logic [16:0] val [4];
    int          n;
    idx = '{CFG_STEAL, CFG_ENVELOPES, CFG_FADE_STEP, CFG_SPARE};
    val = '{17'(steal), 17'(env), fade, 17'($urandom)};
    n   = spare ? 4 : 3;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (idx[k])
        CFG_STEAL:     steal_on = val[k][0];
        CFG_ENVELOPES: env_on   = val[k][0];
        CFG_FADE_STEP: fade_dec = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, and two long hold-offs that back up the block.
  initial begin : result_sink
    int hold;
    int taken;
    out_stall = 1'b0;
    taken     = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1000) hold = LONG_HOLD;
      else hold = $urandom_range(0, stall_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  // Compare each accepted result with the oldest one due.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected result: %s", $realtime, show_result(out_data));
        end
      end else begin
        want = due_results.pop_front();
        if (out_data.voice_slot !== want.voice_slot || out_data.accepted !== want.accepted ||
            out_data.stolen !== want.stolen || out_data.ended_mask !== want.ended_mask ||
            out_data.active_mask !== want.active_mask ||
            out_data.gate_mask !== want.gate_mask) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch: expected %s", $realtime, show_result(want));
            $display("%0t:           got      %s", $realtime, show_result(out_data));
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("polyphonic_voice_allocator_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    phase_t ph;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    gap_max        = 11;
    stall_max      = 11;
    on_pct         = 40;

    // Pool model after reset.
    for (int v = 0; v < NUM_VOICES; v++) begin
      pool_active[v]   = 1'b0;
      pool_gate[v]     = 1'b0;
      pool_note[v]     = '0;
      pool_velocity[v] = '0;
      pool_age[v]      = '0;
      pool_fade[v]     = FADE_UNITY;
    end
    age_clock = '0;
    steal_on  = 1'b1;
    env_on    = 1'b0;
    fade_dec  = FADE_STEP_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Scripted opening under the reset register values.
    add_row(MODE_SPARE_LO, 7'd127, 7'd127, 16'hFFFF, 1, 1,
            {4'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000});
    add_row(MODE_NOTE_ON, 7'd0, 7'd0, 16'h0000, 1, 1,
            {4'd0, 1'b1, 1'b0, 16'h0000, 16'h0001, 16'h0001});
    add_row(MODE_NOTE_ON, 7'd127, 7'd127, 16'h0000, 1, 1,
            {4'd1, 1'b1, 1'b0, 16'h0000, 16'h0003, 16'h0003});
    add_row(MODE_NOTE_OFF, 7'd127, 7'd0, 16'h0000, 1, 1,
            {4'd0, 1'b0, 1'b0, 16'h0000, 16'h0003, 16'h0001});
    add_row(MODE_TICK, 7'd0, 7'd0, 16'hFFFF, 1, 0, '0);
    add_row(MODE_ALL_OFF, 7'd127, 7'd127, 16'hFFFF, 1, 1,
            {4'd0, 1'b0, 1'b0, 16'h0000, 16'h0003, 16'h0000});
    add_row(MODE_SPARE_LO + 3'd1, 7'h55, 7'h2A, 16'h5555, 1, 0, '0);
    // Fill the rest of the pool, then steal the oldest voice.
    add_row(MODE_NOTE_ON, 7'd64, 7'd100, 16'hAAAA, 14, 0, '0);
    add_row(MODE_NOTE_ON, 7'd1, 7'd1, 16'h0000, 1, 0, '0);
    add_row(MODE_NOTE_OFF, 7'd64, 7'h2A, 16'h0000, 1, 0, '0);
    add_row(MODE_SPARE_HI, 7'h2A, 7'h55, 16'hAAAA, 1, 0, '0);
    add_row(MODE_RESET, 7'd0, 7'd0, 16'h0000, 1, 1,
            {4'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000});

    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        offer_event(script[i].item, script[i].typed, script[i].want);
      end
    end
    in_valid <= 1'b0;

    // Random phases: register setting, idling and note-on density per phase.
    phases.insert(phases.size(), '{1'b0, 1'b0, 17'd65536,  11, 11, 55, 205});
    phases.insert(phases.size(), '{1'b1, 1'b1, 17'd0,       0,  0, 40, 205});
    phases.insert(phases.size(), '{1'b0, 1'b1, 17'd131071, 11,  0, 55, 205});
    phases.insert(phases.size(), '{1'b1, 1'b0, 17'd2913,    0, 11, 35, 205});
    phases.insert(phases.size(), '{1'b1, 1'b0, 17'd0,      11, 11, 45, 205});
    phases.insert(phases.size(), '{1'b1, 1'b0, 17'd131071, 11, 11, 30, 205});
    phases.insert(phases.size(),
                  '{1'b0, 1'b0, 17'($urandom_range(1, 65535)), 11, 11, 40, 205});

    foreach (phases[p]) begin
      ph = phases[p];
      program_regs(ph.steal, ph.env, ph.fade, p == 0);
      gap_max   = ph.gap;
      stall_max = ph.stall;
      on_pct    = ph.on_pct;
      note_set[0] = 7'd0;
      note_set[1] = 7'd127;
      for (int k = 2; k < 8; k++) note_set[k] = 7'($urandom_range(0, 127));
      for (int k = 0; k < ph.items; k++) offer_event(random_event(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    // Drain, then give late or stray results time to show up.
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("polyphonic_voice_allocator_unit test passed");
    end else begin
      $display("polyphonic_voice_allocator_unit test failed");
    end
    $finish;
  end

endmodule
